### hdl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants
// Types, register indexes and state codes of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int PIX_W  = 24;  // one RGB pixel, red in the low byte
  localparam int CHAN_W = 8;
  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;
  localparam logic [7:0]  MAG_CLAMP    = 8'd255;

  // configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [PIX_W-1:0]  pix_t;

  // border masks of the result pixel: neighbours beyond a border count as zero
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } mask_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_KICK,
    S_CALC,
    S_OUT
  } state_t;

endpackage

### hdl/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/sem_mag.sv
// ----------------------------------------------------------------------------
// sem_mag: Sobel magnitude of one channel
// Masked 3x3 gradients, sum of squares, then an 8-step bit-serial square root.
// ----------------------------------------------------------------------------
module sem_mag
  import sem_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  chan_t win [3][3],  // [row][column], column 2 newest
  input  mask_t mask,
  output logic  done,
  output chan_t mag
);

  logic [3:0]         ph_r;
  logic               done_r;
  logic signed [11:0] gx_r, gy_r;
  logic [20:0]        sq_r;
  logic [7:0]         root_r;
  logic [2:0]         bit_r;

  logic signed [11:0] v [3][3];
  logic signed [11:0] gx_c, gy_c;
  logic signed [23:0] sqx, sqy;
  logic [7:0]         trial;
  logic [15:0]        trial_sq;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && mask.top) || (r == 2 && mask.bottom) ||
            (c == 0 && mask.left) || (c == 2 && mask.right)) begin
          v[r][c] = '0;
        end else begin
          v[r][c] = $signed({4'b0000, win[r][c]});
        end
      end
    end
    gx_c = (v[0][2] + (v[1][2] <<< 1) + v[2][2]) - (v[0][0] + (v[1][0] <<< 1) + v[2][0]);
    gy_c = (v[2][0] + (v[2][1] <<< 1) + v[2][2]) - (v[0][0] + (v[0][1] <<< 1) + v[0][2]);
    sqx      = gx_r * gx_r;
    sqy      = gy_r * gy_r;
    trial    = root_r | (8'd1 << bit_r);
    trial_sq = trial * trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ph_r <= 4'd1;
      end else if (ph_r == 4'd9) begin
        ph_r   <= '0;
        done_r <= 1'b1;
      end else if (ph_r != '0) begin
        ph_r <= ph_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      gx_r <= gx_c;
      gy_r <= gy_c;
    end else if (ph_r == 4'd1) begin
      sq_r   <= 21'(sqx) + 21'(sqy);
      root_r <= '0;
      bit_r  <= 3'd7;
    end else if (ph_r != '0) begin
      // keep the trial bit where its square still fits
      if ({5'b0, trial_sq} <= sq_r) begin
        root_r <= trial;
      end
      bit_r <= bit_r - 3'd1;
    end
  end

  assign done = done_r;
  assign mag  = (sq_r[20:16] != '0) ? MAG_CLAMP : root_r;

endmodule

### hdl/sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude: streaming 3x3 Sobel edge magnitude on RGB pixels
// Two previous rows live in one line RAM; a 3x3 window feeds three channel
// magnitude units. Results trail their pixel by image_width+1 transfers.
// ----------------------------------------------------------------------------
// Latency: the result of a pixel leaves with the transfer image_width+1 later.
// Items are taken one at a time, through the idle and line RAM read states; an
//   item with a result then waits for the 8-step square root and output state.
// The output register lets a new item in while a result waits to be taken.
// Reset: synchronous, active low; counters, window, state, output valid and size
//   registers cleared to defaults; line RAM and data registers are not cleared.
module sobel_edge_magnitude
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red, green, blue
  input  logic        in_tuser,   // kind: drain item when high
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // edge_red, edge_green, edge_blue
  output logic        out_tlast,  // frame_end
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2) + 1;

  state_t state_r, state_nxt;

  logic [10:0]   width_r;
  logic [12:0]   height_r;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  logic [CW-1:0] in_col_r, out_col_r;
  logic [RW-1:0] in_row_r, out_row_r;
  pix_t          pix_r;
  pix_t          win_r [3][3];
  logic [47:0]   rd_data;

  logic          out_tvalid_r, out_tlast_r;
  logic [23:0]   out_tdata_r;

  logic          accept, emit, col_wrap, last, start, load_out;
  logic          done [3];
  chan_t         mag  [3];
  chan_t         chw  [3][3][3];
  mask_t         mask;

  // effective frame size
  always_comb begin
    if (width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = HW'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_r);
    end
  end

  assign accept   = in_tvalid && in_tready;
  assign emit     = (in_row_r >= RW'(2)) || (in_row_r == RW'(1) && in_col_r != '0);
  assign col_wrap = (32'(in_col_r) + 1) >= 32'(eff_w);
  assign mask.top    = (out_row_r == '0);
  assign mask.bottom = (32'(out_row_r) + 1) >= 32'(eff_h);
  assign mask.left   = (out_col_r == '0);
  assign mask.right  = (32'(out_col_r) + 1) >= 32'(eff_w);
  assign last        = mask.bottom && mask.right;

  // next state and handshake controls
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    start     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = emit ? S_KICK : S_IDLE;
      S_KICK: begin
        start     = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        if (done[0]) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // counters and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RESET;
      height_r  <= HEIGHT_RESET;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_wdata[10:0];
        CFG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (state_r == S_READ && !emit) begin
      in_col_r <= col_wrap ? '0 : in_col_r + CW'(1);
      in_row_r <= col_wrap ? in_row_r + RW'(1) : in_row_r;
    end else if (load_out) begin
      if (last) begin
        // frame done: restart every position
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else begin
        in_col_r  <= col_wrap ? '0 : in_col_r + CW'(1);
        in_row_r  <= col_wrap ? in_row_r + RW'(1) : in_row_r;
        out_col_r <= mask.right ? '0 : out_col_r + CW'(1);
        out_row_r <= mask.right ? out_row_r + RW'(1) : out_row_r;
      end
    end
  end

  // window: shift left, new column from line RAM and the incoming pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (state_r == S_READ) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= rd_data[47:24];
      win_r[1][2] <= rd_data[23:0];
      win_r[2][2] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r <= in_tuser ? '0 : in_tdata;
    end
  end

  // line RAM entry: older row in the top half, newer row in the bottom half
  sem_ram #(
    .WIDTH (48),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (state_r == S_READ),
    .wr_addr (in_col_r),
    .wr_data ({rd_data[23:0], pix_r}),
    .rd_en   (accept),
    .rd_addr (in_col_r),
    .rd_data (rd_data)
  );

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          chw[ch][r][c] = win_r[r][c][ch*CHAN_W +: CHAN_W];
        end
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_mag
    sem_mag u_mag (
      .clk   (clk),
      .rst_n (rst_n),
      .start (start),
      .win   (chw[ch]),
      .mask  (mask),
      .done  (done[ch]),
      .mag   (mag[ch])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata_r <= {mag[2], mag[1], mag[0]};
      out_tlast_r <= last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  a_kick_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_KICK |-> $past(state_r) == S_READ)
    else $error("magnitude start without a line RAM read");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    done[0] |-> state_r == S_CALC && done[1] && done[2])
    else $error("magnitude units out of step");

  a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == S_OUT)
    else $error("result presented outside the output state");

endmodule

### test/sem_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_checker: result checker for the Sobel edge magnitude block
// Watches register writes and both stream channels, keeps its own copy of the
// line store, window and frame counters, and compares every result transfer
// with the oldest predicted edge pixel.
// ----------------------------------------------------------------------------
module sem_checker
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // red, green, blue
  input  logic        in_tuser,   // kind: drain item when high
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // edge_red, edge_green, edge_blue
  input  logic        out_tlast,  // frame_end
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          edge_count,
  output int          frame_count
);

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  frame_end;
  } edge_pix_t;

  edge_pix_t   edge_q[$];
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  pix_t        row_older[MAX_WIDTH];
  pix_t        row_newer[MAX_WIDTH];
  pix_t        win[3][3];
  int unsigned in_col, in_row, out_col, out_row;

  function automatic chan_t clamped_root(int gx, int gy);
    int unsigned s, r, t;
    s = gx * gx + gy * gy;
    r = 0;
    if (s >= 65536) return MAG_CLAMP;
    for (int b = 128; b > 0; b = b >> 1) begin
      t = r | b;
      if (t * t <= s) r = t;
    end
    return r[7:0];
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  task automatic restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endtask

  task automatic predict_edge(input logic drain, input pix_t px);
    int unsigned w, h, col;
    int gx, gy, v;
    pix_t p;
    edge_pix_t e;
    chan_t mag[3];
    w = eff_width();
    h = eff_height();
    col = in_col % MAX_WIDTH;
    p = drain ? '0 : px;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = row_older[col];
    win[1][2] = row_newer[col];
    win[2][2] = p;
    row_older[col] = row_newer[col];
    row_newer[col] = p;
    if (in_row >= 2 || (in_row == 1 && in_col >= 1)) begin
      for (int c = 0; c < 3; c++) begin
        gx = 0;
        gy = 0;
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            // drop neighbours beyond the frame border
            if ((i == 0 && out_row == 0) || (i == 2 && out_row + 1 >= h) ||
                (j == 0 && out_col == 0) || (j == 2 && out_col + 1 >= w)) continue;
            v = win[i][j][8*c +: 8];
            gx += v * (j - 1) * ((i == 1) ? 2 : 1);
            gy += v * (i - 1) * ((j == 1) ? 2 : 1);
          end
        end
        mag[c] = clamped_root(gx, gy);
      end
      e.red = mag[0];
      e.green = mag[1];
      e.blue = mag[2];
      e.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
      edge_q.push_back(e);
      if (e.frame_end) begin
        restart_frame();
        return;
      end
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
  endtask

  task automatic check_edge();
    edge_pix_t e;
    if (edge_q.size() == 0) begin
      $error("unexpected result transfer: data %h last %b", out_tdata, out_tlast);
      fail_count++;
      return;
    end
    e = edge_q.pop_front();
    edge_count++;
    if (out_tlast) frame_count++;
    if (out_tdata[7:0] !== e.red) begin
      $error("edge_red: expected %0d, actual %0d", e.red, out_tdata[7:0]);
      fail_count++;
    end
    if (out_tdata[15:8] !== e.green) begin
      $error("edge_green: expected %0d, actual %0d", e.green, out_tdata[15:8]);
      fail_count++;
    end
    if (out_tdata[23:16] !== e.blue) begin
      $error("edge_blue: expected %0d, actual %0d", e.blue, out_tdata[23:16]);
      fail_count++;
    end
    if (out_tlast !== e.frame_end) begin
      $error("frame_end: expected %0d, actual %0d", e.frame_end, out_tlast);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    edge_count = 0;
    frame_count = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      edge_q.delete();
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_older[i] = '0;
        row_newer[i] = '0;
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win[i][j] = '0;
      restart_frame();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) width_reg = cfg_wdata[10:0];
        else height_reg = cfg_wdata;
        restart_frame();
      end
      if (in_tvalid && in_tready) predict_edge(in_tuser, in_tdata);
      if (out_tvalid && out_tready) check_edge();
    end
    pending = edge_q.size();
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the Sobel edge magnitude block
// Streams directed and random RGB frames with drain tails through the block,
// with random gaps and stalls and one long output hold-off, across several
// frame sizes; a separate checker predicts and compares every edge pixel.
// ----------------------------------------------------------------------------
module tb_top;
  import sem_pkg::*;

  localparam int LIMIT = 2_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_WIDTH;
  logic [12:0] cfg_wdata = '0;

  int fail_count, pending, edge_count, frame_count;
  int items_sent = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int unsigned cur_w, cur_h;

  always #10 clk = ~clk;

  sobel_edge_magnitude i_dut (.*);

  sem_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_we, .cfg_index, .cfg_wdata,
    .fail_count, .pending, .edge_count, .frame_count
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("sobel_edge_magnitude: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (800) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic push(input logic drain, input pix_t px);
    in_tvalid <= 1'b1;
    in_tuser <= drain;
    in_tdata <= px;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [12:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH) cur_w = (val[10:0] == 0) ? 1 : (val[10:0] > 1024) ? 1024 : val[10:0];
    else cur_h = (val == 0) ? 1 : (val > 4096) ? 4096 : val;
  endtask

  function automatic pix_t rand_pix();
    pix_t p;
    p = pix_t'($urandom);
    // saturated channels drive the magnitude into the clamp
    if ($urandom_range(0, 2) == 0)
      for (int c = 0; c < 3; c++) p[8*c +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return p;
  endfunction

  // one frame plus its drain tail; cut > 0 abandons it after that many items
  task automatic send_frame(input int cut);
    int total;
    total = cur_w * cur_h + cur_w + 1;
    if (cut > 0) total = cut;
    for (int i = 0; i < total; i++) begin
      if (i < cur_w * cur_h) push($urandom_range(0, 24) == 0, rand_pix());
      else push($urandom_range(0, 5) != 0, rand_pix());
    end
  endtask

  initial begin
    int w, h;
    bit reconfig;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x3 checkerboard with a black drain in the middle, a pixel in the tail
    write_reg(CFG_WIDTH, 13'd3);
    write_reg(CFG_HEIGHT, 13'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) push(1'b1, 24'hFFFFFF);
      else push(1'b0, (i % 2) ? 24'h000000 : 24'hFFFFFF);
    end
    push(1'b1, '0);
    push(1'b0, 24'hFFFFFF);
    push(1'b1, '0);
    push(1'b1, '0);
    // zero sizes fall back to a single pixel
    write_reg(CFG_WIDTH, 13'd0);
    write_reg(CFG_HEIGHT, 13'd0);
    push(1'b0, 24'hFFFFFF);
    push(1'b0, 24'h00FF00);
    push(1'b1, '0);

    reconfig = 1'b1;
    for (int n = 0; items_sent < 1700; n++) begin
      if (items_sent > 1450) calm = 1'b1;
      if (reconfig || $urandom_range(0, 2) == 0) begin
        w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
        h = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 8);
        write_reg(CFG_WIDTH, 13'(w));
        write_reg(CFG_HEIGHT, 13'(h));
      end
      reconfig = 1'b0;
      if (n == 4) begin
        // hold results back while a whole frame keeps coming
        write_reg(CFG_WIDTH, 13'd6);
        write_reg(CFG_HEIGHT, 13'd6);
        hold_req = 1'b1;
        send_frame(0);
      end else if ($urandom_range(0, 9) == 0) begin
        send_frame($urandom_range(1, cur_w * cur_h + cur_w));
        reconfig = 1'b1;
      end else begin
        send_frame(0);
      end
    end
    settle();

    $display("%0d items streamed, %0d edge pixels checked over %0d complete frames",
             items_sent, edge_count, frame_count);
    $display("sizes ran from 1x1 to 40x20, with drains inside frames and abandoned frames");
    if (fail_count == 0) begin
      $display("sobel_edge_magnitude: match");
    end else begin
      $display("sobel_edge_magnitude: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
hdl/sem_pkg.sv
hdl/sem_ram.sv
hdl/sem_mag.sv
hdl/sobel_edge_magnitude.sv
test/sem_checker.sv
test/tb_top.sv
